/* hw/rtl/vtpd_pkg.sv */
// Package for the vertex transform with perspective divide.
// Holds fixed-point widths, configuration codes and the pipeline control type.
// No dependencies.
package vtpd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int MAG_W     = 57;
    localparam int DIV_N     = COORD_W;
    localparam int CMP_W     = MAG_W + COORD_W - FRAC_BITS;
    localparam int NUM_ELEM  = 16;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 64;
    localparam int NUM_LANES = 3;

    localparam logic signed [COORD_W-1:0] ONE_FX = COORD_W'(1) << FRAC_BITS;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [MAG_W-1:0]          mag_t;

    typedef struct packed {
        logic                 w_zero;
        logic [NUM_LANES-1:0] neg;
        logic [NUM_LANES-1:0] ovf;
    } div_ctl_t;

endpackage

/* hw/rtl/vtpd_if.sv */
// Channel interfaces: point input, result output and configuration write.
// Depends on vtpd_pkg.
interface vtpd_in_if;
    import vtpd_pkg::*;
    logic   valid;
    logic   ready;
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface vtpd_out_if;
    import vtpd_pkg::*;
    logic   valid;
    logic   ready;
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   w_zero;
    logic   saturated;
    modport source (output valid, output out_x, output out_y, output out_z,
                    output w_zero, output saturated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input w_zero, input saturated, output ready);
endinterface

interface vtpd_cfg_if;
    import vtpd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/vtpd_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vtpd_pkg.
module vtpd_div (
    input  logic                        clk,
    input  logic                        en,
    input  vtpd_pkg::mag_t              rem_in,
    input  logic [vtpd_pkg::DIV_N-1:0]  dlo_in,
    input  vtpd_pkg::mag_t              nw_in,
    output logic [vtpd_pkg::DIV_N-1:0]  q
);
    import vtpd_pkg::*;

    mag_t             rem_reg [0:DIV_N];
    logic [DIV_N-1:0] dlo_reg [0:DIV_N];
    logic [DIV_N-1:0] q_reg   [0:DIV_N];
    mag_t             nw_reg  [0:DIV_N];

    always_comb
    begin
        rem_reg[0] = rem_in;
        dlo_reg[0] = dlo_in;
        q_reg[0]   = '0;
        nw_reg[0]  = nw_in;
    end

    for (genvar k = 0; k < DIV_N; k++) begin : g_stage
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           ge;

        always_comb
        begin
            trial = {rem_reg[k], dlo_reg[k][DIV_N-1]};
            diff  = trial - {1'b0, nw_reg[k]};
            ge    = trial >= {1'b0, nw_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                dlo_reg[k+1] <= {dlo_reg[k][DIV_N-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][DIV_N-2:0], ge};
                nw_reg[k+1]  <= nw_reg[k];
            end
        end
    end

    assign q = q_reg[DIV_N];

endmodule

/* hw/rtl/vertex_transform_perspective_divide.sv */
// Vertex transform with perspective divide, top level.
// Accepts 1 point/cycle while the output register is empty or taken.
// Stages: multiply, row sum, divide setup, 32 divider stages, saturate/output.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears valid bits and loads the identity matrix. Depends on vtpd_pkg, vtpd_if, vtpd_div.
module vertex_transform_perspective_divide (
    input  logic      clk,
    input  logic      rst_n,
    vtpd_in_if.sink   pt,
    vtpd_out_if.source res,
    vtpd_cfg_if.sink  cfg
);
    import vtpd_pkg::*;

    localparam int NST = 3 + DIV_N;

    coord_t                    mat_reg [NUM_ELEM];
    logic [NST-1:0]            vld_reg;
    logic                      out_vld_reg;
    logic                      adv;

    logic signed [PROD_W-1:0]  prod_reg [4][3];
    logic signed [PROD_W-1:0]  sum_next [4];
    logic signed [PROD_W-1:0]  sum_reg  [4];

    mag_t                      mag   [4];
    logic                      sgn   [4];
    mag_t                      rem0_reg [NUM_LANES];
    logic [DIV_N-1:0]          dlo0_reg [NUM_LANES];
    mag_t                      nw_reg;
    div_ctl_t                  ctl_next;
    div_ctl_t                  ctl_reg [0:DIV_N];
    logic [DIV_N-1:0]          q [NUM_LANES];

    coord_t                    res_next [NUM_LANES];
    logic [NUM_LANES-1:0]      sat_next;

    assign adv       = !out_vld_reg || res.ready;
    assign pt.ready  = adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ELEM; i++)
            begin
                mat_reg[i] <= ((i % 5) == 0) ? ONE_FX : '0;
            end
        end
        else if (cfg.valid && cfg.index < CFG_IDX_W'(NUM_REGS))
        begin
            mat_reg[{cfg.index[2:0], 1'b0}] <= cfg.data[31:0];
            mat_reg[{cfg.index[2:0], 1'b1}] <= cfg.data[63:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NST-2:0], pt.valid};
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    // multiply
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                prod_reg[r][0] <= PROD_W'(mat_reg[r])     * PROD_W'(pt.in_x);
                prod_reg[r][1] <= PROD_W'(mat_reg[r + 4]) * PROD_W'(pt.in_y);
                prod_reg[r][2] <= PROD_W'(mat_reg[r + 8]) * PROD_W'(pt.in_z);
            end
        end
    end

    // row sums
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum_next[r] = PROD_W'(mat_reg[r + 12])
                        + (prod_reg[r][0] >>> FRAC_BITS)
                        + (prod_reg[r][1] >>> FRAC_BITS)
                        + (prod_reg[r][2] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= sum_next;
        end
    end

    // divide setup
    always_comb
    begin
        logic [PROD_W-1:0] a;
        for (int r = 0; r < 4; r++)
        begin
            sgn[r] = sum_reg[r][PROD_W-1];
            a      = sgn[r] ? -sum_reg[r] : sum_reg[r];
            mag[r] = a[MAG_W-1:0];
        end
        ctl_next.w_zero = (sum_reg[3] == '0);
        for (int l = 0; l < NUM_LANES; l++)
        begin
            ctl_next.neg[l] = sgn[l] ^ sgn[3];
            ctl_next.ovf[l] = CMP_W'(mag[l]) >= (CMP_W'(mag[3]) << (COORD_W - FRAC_BITS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nw_reg     <= mag[3];
            ctl_reg[0] <= ctl_next;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                rem0_reg[l] <= MAG_W'(mag[l] >> (COORD_W - FRAC_BITS));
                dlo0_reg[l] <= {mag[l][COORD_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
            end
            for (int k = 0; k < DIV_N; k++)
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        vtpd_div u_div (
            .clk    (clk),
            .en     (adv),
            .rem_in (rem0_reg[l]),
            .dlo_in (dlo0_reg[l]),
            .nw_in  (nw_reg),
            .q      (q[l])
        );
    end

    // saturate and sign
    always_comb
    begin
        logic [DIV_N:0] lim;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            lim = ctl_reg[DIV_N].neg[l] ? (DIV_N+1)'(33'h080000000)
                                         : (DIV_N+1)'(33'h07FFFFFFF);
            if (ctl_reg[DIV_N].ovf[l] || {1'b0, q[l]} > lim)
            begin
                sat_next[l] = 1'b1;
                res_next[l] = ctl_reg[DIV_N].neg[l] ? coord_t'(32'h80000000)
                                                    : coord_t'(32'h7FFFFFFF);
            end
            else
            begin
                sat_next[l] = 1'b0;
                res_next[l] = ctl_reg[DIV_N].neg[l] ? -coord_t'(q[l]) : coord_t'(q[l]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (ctl_reg[DIV_N].w_zero)
            begin
                res.out_x     <= '0;
                res.out_y     <= '0;
                res.out_z     <= '0;
                res.w_zero    <= 1'b1;
                res.saturated <= 1'b0;
            end
            else
            begin
                res.out_x     <= res_next[0];
                res.out_y     <= res_next[1];
                res.out_z     <= res_next[2];
                res.w_zero    <= 1'b0;
                res.saturated <= |sat_next;
            end
        end
    end

    assign res.valid = out_vld_reg;

endmodule
